// File: rtl/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, constants and helper functions for the infix to postfix
// converter (operator codes, character classes, controller/datapath bundles).
// ----------------------------------------------------------------------------
package i2p_pkg;

    // Stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    // The top entry lives in a register; the rest sit in the memory
    localparam int MEM_DEPTH   = STACK_DEPTH - 1;
    localparam int ADDR_W      = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // ASCII characters of interest
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_D0    = 8'h30;
    localparam logic [7:0] CH_D9    = 8'h39;

    // Stack entry codes
    typedef logic [2:0] t_op;
    localparam t_op OP_OPEN  = 3'd0;
    localparam t_op OP_ADD   = 3'd1;
    localparam t_op OP_SUB   = 3'd2;
    localparam t_op OP_MUL   = 3'd3;
    localparam t_op OP_DIV   = 3'd4;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNMATCHED = 2'd2;

    // Character class of the latched input symbol
    typedef enum logic [2:0] {
        CL_ALNUM = 3'd0,
        CL_OPEN  = 3'd1,
        CL_CLOSE = 3'd2,
        CL_OP    = 3'd3,
        CL_OTHER = 3'd4
    } t_cls;

    // Source of an emitted result
    typedef enum logic [1:0] {
        EM_CHAR = 2'd0,
        EM_TOP  = 2'd1,
        EM_OVF  = 2'd2,
        EM_UNM  = 2'd3
    } t_emit_src;

    // What is pushed
    typedef enum logic {
        PU_OPEN = 1'b0,
        PU_OP   = 1'b1
    } t_push_src;

    // Controller to datapath commands
    typedef struct packed {
        logic      load_in;
        logic      emit;
        t_emit_src emit_src;
        logic      push;
        t_push_src push_src;
        logic      pop;
        logic      load_top;
        logic      finish;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_cls cls;
        logic end_flag;
        logic empty;
        logic full;
        logic top_is_open;
        logic top_ge;
        logic can_emit;
        logic can_finish;
        logic pend_v;
    } t_dp_sts;

    // Character printed for a stack entry
    function automatic logic [7:0] code_char(input t_op code);
        logic [7:0] ch;
        case (code)
            OP_OPEN: ch = CH_OPEN;
            OP_ADD:  ch = CH_PLUS;
            OP_SUB:  ch = CH_MINUS;
            OP_MUL:  ch = CH_STAR;
            OP_DIV:  ch = CH_SLASH;
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    // Precedence of a stack entry
    function automatic logic [1:0] code_prec(input t_op code);
        logic [1:0] p;
        case (code)
            OP_ADD, OP_SUB: p = 2'd1;
            OP_MUL, OP_DIV: p = 2'd2;
            default:        p = 2'd0;
        endcase
        return p;
    endfunction

    // Operator code of a character (OP_OPEN when not an operator)
    function automatic t_op op_of(input logic [7:0] ch);
        t_op c;
        case (ch)
            CH_PLUS:  c = OP_ADD;
            CH_MINUS: c = OP_SUB;
            CH_STAR:  c = OP_MUL;
            CH_SLASH: c = OP_DIV;
            default:  c = OP_OPEN;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Converts an infix character stream to postfix with an operator stack.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+-------------------------------------
//   in      | i_in_valid/o_in_ready  | i_symbol, i_end_of_expr
//   out     | o_out_valid/i_out_ready| o_out_symbol, o_has_symbol,
//           |                        | o_last_of_run, o_expr_done, o_status
//
// An item steps through accept, decode, end check and close-out; an operator
// or a ')' adds a step of its own, and each stack pop is followed by a top reload.
// Results leave through a holding register and an output register, so the
// next character is accepted while the last result still waits.
// Synchronous active-low reset empties the stack; no clearing pass is needed.
// A stalled output holds the sequencer in place until room appears.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
    import i2p_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_symbol,
    input  logic       i_end_of_expr,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_symbol,
    output logic       o_has_symbol,
    output logic       o_last_of_run,
    output logic       o_expr_done,
    output logic [1:0] o_status
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequencer
    i2p_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Stack and result path
    i2p_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_symbol      (i_symbol),
        .i_end_of_expr (i_end_of_expr),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_symbol  (o_out_symbol),
        .o_has_symbol  (o_has_symbol),
        .o_last_of_run (o_last_of_run),
        .o_expr_done   (o_expr_done),
        .o_status      (o_status)
    );

endmodule

// File: rtl/i2p_ctrl.sv
// ----------------------------------------------------------------------------
// i2p_ctrl
// Sequencer for the converter: decodes each character and steps the
// datapath through pops, pushes, result emission and end-of-item close.
// ----------------------------------------------------------------------------
module i2p_ctrl
    import i2p_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_CLOSE  = 7'b0000100,
        S_OPPOP  = 7'b0001000,
        S_FLUSH  = 7'b0010000,
        S_LOAD   = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    t_state r_ret,   n_ret;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command decode
    always_comb begin
        n_state        = r_state;
        n_ret          = r_ret;
        o_cmd          = '0;
        o_cmd.emit_src = EM_CHAR;
        o_cmd.push_src = PU_OPEN;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.cls)
                    CL_ALNUM: begin
                        if (i_sts.can_emit) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_src = EM_CHAR;
                            n_state        = S_FLUSH;
                        end
                    end
                    CL_OPEN: begin
                        if (!i_sts.full) begin
                            o_cmd.push     = 1'b1;
                            o_cmd.push_src = PU_OPEN;
                            n_state        = S_FLUSH;
                        end else if (i_sts.can_emit) begin
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_src = EM_OVF;
                            n_state        = S_FLUSH;
                        end
                    end
                    CL_CLOSE: n_state = S_CLOSE;
                    CL_OP:    n_state = S_OPPOP;
                    default:  n_state = S_FLUSH;
                endcase
            end
            // Pop operators down to the matching open parenthesis
            S_CLOSE: begin
                if (i_sts.empty) begin
                    if (i_sts.can_emit) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_src = EM_UNM;
                        n_state        = S_FLUSH;
                    end
                end else if (i_sts.top_is_open) begin
                    o_cmd.pop = 1'b1;
                    n_ret     = S_FLUSH;
                    n_state   = S_LOAD;
                end else if (i_sts.can_emit) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = EM_TOP;
                    o_cmd.pop      = 1'b1;
                    n_ret          = S_CLOSE;
                    n_state        = S_LOAD;
                end
            end
            // Pop entries of greater or equal precedence, then push
            S_OPPOP: begin
                if (!i_sts.empty && i_sts.top_ge) begin
                    if (i_sts.can_emit) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_src = EM_TOP;
                        o_cmd.pop      = 1'b1;
                        n_ret          = S_OPPOP;
                        n_state        = S_LOAD;
                    end
                end else if (!i_sts.full) begin
                    o_cmd.push     = 1'b1;
                    o_cmd.push_src = PU_OP;
                    n_state        = S_FLUSH;
                end else if (i_sts.can_emit) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_src = EM_OVF;
                    n_state        = S_FLUSH;
                end
            end
            // End check: at the end of an expression, empty the stack
            S_FLUSH: begin
                if (i_sts.end_flag && !i_sts.empty) begin
                    if (i_sts.can_emit) begin
                        o_cmd.emit     = 1'b1;
                        o_cmd.emit_src = EM_TOP;
                        o_cmd.pop      = 1'b1;
                        n_ret          = S_FLUSH;
                        n_state        = S_LOAD;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_LOAD: begin
                o_cmd.load_top = 1'b1;
                n_state        = r_ret;
            end
            S_FINISH: begin
                if (i_sts.can_finish) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_FLUSH;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    // A new item never starts with a result still held back
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.pend_v)
        else $error("pending result left over in idle");

    // Every pop is followed by a reload of the top entry
    a_pop_then_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop |=> (r_state == S_LOAD))
        else $error("pop not followed by top reload");

    // Finish only after the item has been decoded
    a_finish_after_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) |-> ($past(r_state) == S_FLUSH || $past(r_state) == S_FINISH))
        else $error("finish reached from wrong state");

endmodule

// File: rtl/i2p_datapath.sv
// ----------------------------------------------------------------------------
// i2p_datapath
// Input latch, operator stack (top register plus memory), a one-deep
// holding register for the newest result and the output register.
// ----------------------------------------------------------------------------
module i2p_datapath
    import i2p_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_cmd,
    output t_dp_sts       o_sts,
    input  logic [7:0]    i_symbol,
    input  logic          i_end_of_expr,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_out_symbol,
    output logic          o_has_symbol,
    output logic          o_last_of_run,
    output logic          o_expr_done,
    output logic [1:0]    o_status
);

    // Latched input item
    logic [7:0]       r_sym;
    logic             r_end;

    // Stack
    logic [CNT_W-1:0] r_count;
    t_op              r_top;
    t_op              r_rdata;
    t_op              mem [MEM_DEPTH];

    // Held result (newest, lastness not yet known)
    logic             r_pend_v;
    logic [7:0]       r_pend_sym;
    logic             r_pend_has;
    t_status          r_pend_st;

    // Output register
    logic             r_out_v;
    logic [7:0]       r_out_sym;
    logic             r_out_has;
    logic             r_out_last;
    logic             r_out_done;
    t_status          r_out_st;

    t_cls             cls;
    t_op              sym_op;
    logic             out_free;
    logic             move;
    logic [7:0]       em_sym;
    logic             em_has;
    t_status          em_st;
    t_op              push_code;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_m2;

    // Character classification
    always_comb begin
        sym_op = op_of(r_sym);
        if ((r_sym >= CH_LC_A && r_sym <= CH_LC_Z) ||
            (r_sym >= CH_UC_A && r_sym <= CH_UC_Z) ||
            (r_sym >= CH_D0 && r_sym <= CH_D9)) begin
            cls = CL_ALNUM;
        end else if (r_sym == CH_OPEN) begin
            cls = CL_OPEN;
        end else if (r_sym == CH_CLOSE) begin
            cls = CL_CLOSE;
        end else if (sym_op != OP_OPEN) begin
            cls = CL_OP;
        end else begin
            cls = CL_OTHER;
        end
    end

    assign out_free = !r_out_v || i_out_ready;
    assign move     = r_pend_v && (i_cmd.emit || i_cmd.finish);
    assign cnt_m1   = r_count - CNT_W'(1);
    assign cnt_m2   = r_count - CNT_W'(2);

    // Status to the controller
    always_comb begin
        o_sts.cls         = cls;
        o_sts.end_flag    = r_end;
        o_sts.empty       = (r_count == '0);
        o_sts.full        = (r_count == CNT_W'(STACK_DEPTH));
        o_sts.top_is_open = (r_top == OP_OPEN);
        o_sts.top_ge      = (code_prec(r_top) >= code_prec(sym_op));
        o_sts.can_emit    = !r_pend_v || out_free;
        o_sts.can_finish  = out_free;
        o_sts.pend_v      = r_pend_v;
    end

    // Result being emitted
    always_comb begin
        case (i_cmd.emit_src)
            EM_CHAR: begin
                em_sym = r_sym;
                em_has = 1'b1;
                em_st  = ST_OK;
            end
            EM_TOP: begin
                em_sym = code_char(r_top);
                em_has = 1'b1;
                em_st  = ST_OK;
            end
            EM_OVF: begin
                em_sym = 8'd0;
                em_has = 1'b0;
                em_st  = ST_OVERFLOW;
            end
            default: begin
                em_sym = 8'd0;
                em_has = 1'b0;
                em_st  = ST_UNMATCHED;
            end
        endcase
    end

    assign push_code = (i_cmd.push_src == PU_OP) ? sym_op : OP_OPEN;

    // Input latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_sym <= i_symbol;
            r_end <= i_end_of_expr;
        end
    end

    // Stack count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            r_count <= cnt_m1;
        end
    end

    // Top register; old top spills into memory on a push
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_top <= push_code;
        end else if (i_cmd.load_top) begin
            r_top <= r_rdata;
        end
    end

    // Stack memory, registered read of the entry below the top
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && r_count != '0) begin
            mem[cnt_m1[ADDR_W-1:0]] <= r_top;
        end
        if (i_cmd.pop && r_count >= CNT_W'(2)) begin
            r_rdata <= mem[cnt_m2[ADDR_W-1:0]];
        end
    end

    // Held result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
        end else if (i_cmd.emit) begin
            r_pend_v <= 1'b1;
        end else if (i_cmd.finish) begin
            r_pend_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_pend_sym <= em_sym;
            r_pend_has <= em_has;
            r_pend_st  <= em_st;
        end
    end

    // Output register: takes the held result or the closing marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (move || (i_cmd.finish && r_end)) begin
            r_out_v <= 1'b1;
        end else if (i_out_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_sym  <= r_pend_sym;
            r_out_has  <= r_pend_has;
            r_out_st   <= r_pend_st;
            r_out_last <= i_cmd.finish;
            r_out_done <= i_cmd.finish && r_end;
        end else if (i_cmd.finish && r_end) begin
            r_out_sym  <= 8'd0;
            r_out_has  <= 1'b0;
            r_out_st   <= ST_OK;
            r_out_last <= 1'b1;
            r_out_done <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_out_symbol  = r_out_sym;
    assign o_has_symbol  = r_out_has;
    assign o_last_of_run = r_out_last;
    assign o_expr_done   = r_out_done;
    assign o_status      = r_out_st;

    // Stack never holds more than its depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // A result is only produced when it has somewhere to go
    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_pend_v || out_free))
        else $error("result emitted with no room");

    // No push onto a full stack, no pop from an empty one
    a_stack_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push |-> r_count != CNT_W'(STACK_DEPTH)) and (i_cmd.pop |-> r_count != '0))
        else $error("stack bound violated");

    // Closing an item leaves nothing held back
    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> !r_pend_v)
        else $error("held result survives finish");

endmodule

// File: tb/postfix_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// postfix_check_pkg
// Scoreboard for the infix to postfix converter: keeps its own operator stack,
// works out the postfix results of every accepted character and checks the
// results that leave the block against them, oldest first.
// ----------------------------------------------------------------------------
package postfix_check_pkg;

    import i2p_pkg::*;

    // One result as seen on the output channel
    typedef struct packed {
        logic [7:0] symbol;
        logic       has;
        logic       last;
        logic       done;
        t_status    status;
    } pf_result_t;

    class postfix_scoreboard;

        localparam int MAX_PRINTED = 100;

        t_op        op_stack [STACK_DEPTH];
        int         stack_used;
        pf_result_t expected_q [$];
        int         n_errors;
        int         n_checked;

        function new();
            stack_used = 0;
            n_errors   = 0;
            n_checked  = 0;
        endfunction

        // Character printed for a stacked entry
        function logic [7:0] printed_char(t_op code);
            case (code)
                OP_ADD:  return CH_PLUS;
                OP_SUB:  return CH_MINUS;
                OP_MUL:  return CH_STAR;
                OP_DIV:  return CH_SLASH;
                default: return CH_OPEN;
            endcase
        endfunction

        // Binding strength; '(' binds weakest so nothing pops past it
        function int rank(t_op code);
            if (code == OP_MUL || code == OP_DIV)
                return 2;
            else if (code == OP_ADD || code == OP_SUB)
                return 1;
            return 0;
        endfunction

        function void add_result(logic [7:0] sym, logic has, t_status st);
            pf_result_t r;
            r.symbol = has ? sym : 8'd0;
            r.has    = has;
            r.last   = 1'b0;
            r.done   = 1'b0;
            r.status = st;
            expected_q.push_back(r);
        endfunction

        // Full stack: the push is dropped and flagged
        function void push_entry(t_op code);
            if (stack_used >= STACK_DEPTH) begin
                add_result(8'd0, 1'b0, ST_OVERFLOW);
            end else begin
                op_stack[stack_used] = code;
                stack_used++;
            end
        endfunction

        function t_op pop_entry();
            stack_used--;
            return op_stack[stack_used];
        endfunction

        // Works out the results of one accepted character; returns 0 when the
        // character is one the block ignores
        function bit note_input(logic [7:0] sym, logic end_flag);
            int         first;
            t_op        code;
            bit         matched;
            bit         handled;
            pf_result_t tail;
            first   = expected_q.size();
            handled = 1'b1;
            case (sym)
                CH_OPEN: begin
                    push_entry(OP_OPEN);
                end
                CH_CLOSE: begin
                    // pop down to the matching '(' or flag it as unmatched
                    matched = 1'b0;
                    while (stack_used > 0 && !matched) begin
                        code = pop_entry();
                        if (code == OP_OPEN)
                            matched = 1'b1;
                        else
                            add_result(printed_char(code), 1'b1, ST_OK);
                    end
                    if (!matched)
                        add_result(8'd0, 1'b0, ST_UNMATCHED);
                end
                CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: begin
                    code = (sym == CH_PLUS)  ? OP_ADD :
                           (sym == CH_MINUS) ? OP_SUB :
                           (sym == CH_STAR)  ? OP_MUL : OP_DIV;
                    while (stack_used > 0 && rank(op_stack[stack_used - 1]) >= rank(code))
                        add_result(printed_char(pop_entry()), 1'b1, ST_OK);
                    push_entry(code);
                end
                default: begin
                    if ((sym >= CH_LC_A && sym <= CH_LC_Z) ||
                        (sym >= CH_UC_A && sym <= CH_UC_Z) ||
                        (sym >= CH_D0 && sym <= CH_D9))
                        add_result(sym, 1'b1, ST_OK);
                    else
                        handled = 1'b0;
                end
            endcase

            // End of expression: flush, a leftover '(' comes out as itself
            if (end_flag) begin
                while (stack_used > 0)
                    add_result(printed_char(pop_entry()), 1'b1, ST_OK);
                if (expected_q.size() == first)
                    add_result(8'd0, 1'b0, ST_OK);
            end

            if (expected_q.size() > first) begin
                tail      = expected_q.pop_back();
                tail.last = 1'b1;
                tail.done = end_flag;
                expected_q.push_back(tail);
            end
            return handled;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what);
            n_errors++;
            if (n_errors <= MAX_PRINTED)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        // Compares one transfer on the output channel with the oldest expectation
        task check_result(logic [7:0] symbol, logic has, logic last, logic done,
                          logic [1:0] status);
            pf_result_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d not expected (symbol %h has %b status %0d)",
                                 n_checked, symbol, has, status));
                n_checked++;
                return;
            end
            want = expected_q.pop_front();
            if (symbol !== want.symbol)
                report($sformatf("result %0d out_symbol %h, want %h",
                                 n_checked, symbol, want.symbol));
            if (has !== want.has)
                report($sformatf("result %0d has_symbol %b, want %b",
                                 n_checked, has, want.has));
            if (last !== want.last)
                report($sformatf("result %0d last_of_run %b, want %b",
                                 n_checked, last, want.last));
            if (done !== want.done)
                report($sformatf("result %0d expr_done %b, want %b",
                                 n_checked, done, want.done));
            if (status !== want.status)
                report($sformatf("result %0d status %0d, want %0d",
                                 n_checked, status, want.status));
            n_checked++;
        endtask

    endclass

endpackage

// File: tb/tb_infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter
// Feeds directed and random character streams (well-formed expressions, deep
// nesting, broken sequences and noise bytes) into the converter with random
// gaps and back-pressure, and checks every result against the scoreboard.
// ----------------------------------------------------------------------------
module tb_infix_to_postfix_converter;

    import i2p_pkg::*;
    import postfix_check_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int RANDOM_ITEMS    = 230;
    localparam int QUIET_ITEMS     = 40;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int DRAIN_CYCLES    = 60;
    localparam int CYCLE_LIMIT     = 400000;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [7:0] in_symbol  = 8'd0;
    logic       in_end     = 1'b0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] out_symbol;
    logic       has_symbol;
    logic       last_of_run;
    logic       expr_done;
    logic [1:0] status;

    bit         gaps_on      = 1'b0;
    bit         hold_off_req = 1'b0;
    int         n_handled    = 0;
    int         cycle_count  = 0;

    postfix_scoreboard sb = new();

    infix_to_postfix_converter u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_symbol      (in_symbol),
        .i_end_of_expr (in_end),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_out_symbol  (out_symbol),
        .o_has_symbol  (has_symbol),
        .o_last_of_run (last_of_run),
        .o_expr_done   (expr_done),
        .o_status      (status)
    );

    // 10 ns clock
    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output monitor: every transfer is checked
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_symbol, has_symbol, last_of_run, expr_done, status);
    end

    // Receiver: short stall bursts, or one long hold-off on request
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_off_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                out_ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offers one character and waits for its transfer; starts and ends at a
    // falling edge
    task automatic send_item(input logic [7:0] sym, input logic last_char);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_symbol <= sym;
        in_end    <= last_char;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (sb.note_input(sym, last_char))
            n_handled++;
        @(negedge clk);
    endtask

    // Sends a string, end of expression on its last character
    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_item(s[k], k == s.len() - 1);
    endtask

    function automatic logic [7:0] random_operand();
        case ($urandom_range(0, 2))
            0:       return CH_LC_A + 8'($urandom_range(0, 25));
            1:       return CH_UC_A + 8'($urandom_range(0, 25));
            default: return CH_D0 + 8'($urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Well-formed infix with random operands, operators and nesting
    function automatic void add_expr(ref logic [7:0] seq[$], input int level);
        int terms;
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++) begin
            if (t != 0)
                seq.push_back(random_operator());
            if (level < 3 && $urandom_range(0, 3) == 0) begin
                seq.push_back(CH_OPEN);
                add_expr(seq, level + 1);
                seq.push_back(CH_CLOSE);
            end else begin
                seq.push_back(random_operand());
            end
            // the odd space, which the block skips
            if ($urandom_range(0, 15) == 0)
                seq.push_back(8'h20);
        end
    endfunction

    // Stimulus
    initial begin
        logic [7:0] seq[$];
        string      pool;
        int         round;
        bit         close_it;

        pool = "()(+-*/aZ5 )";
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: all operators, precedence, operand extremes
        send_text("a+B*(0-9)/z");
        // ignored extremes, then an end marker on an ignored character
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b1);
        // unmatched ')' on an empty stack and after popping an operator
        send_item(CH_CLOSE, 1'b0);
        send_text("A-Z)");
        // open parentheses left at the end
        send_text("((x");
        // lone operator ending an expression
        send_item(CH_PLUS, 1'b1);

        // Random part
        n_handled = 0;
        round     = 0;
        while (n_handled < RANDOM_ITEMS) begin
            gaps_on = (n_handled < RANDOM_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
            if (round == 2 || round == 18)
                hold_off_req = 1'b1;
            seq.delete();
            if (round % 10 == 4) begin
                // fill the stack past its depth, then flush it
                repeat (STACK_DEPTH + 1) seq.push_back(CH_OPEN);
                repeat ($urandom_range(0, 2)) seq.push_back(random_operator());
                seq.push_back(random_operand());
                close_it = 1'b1;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        // noise bytes
                        repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(0, 255)));
                        close_it = ($urandom_range(0, 3) == 0);
                    end
                    1: begin
                        // broken sequences from a pool rich in brackets
                        repeat ($urandom_range(1, 8))
                            seq.push_back(pool[$urandom_range(0, pool.len() - 1)]);
                        close_it = $urandom_range(0, 1);
                    end
                    default: begin
                        add_expr(seq, 0);
                        close_it = 1'b1;
                    end
                endcase
            end
            foreach (seq[k])
                send_item(seq[k], close_it && (k == seq.size() - 1));
            round++;
        end
        gaps_on = 1'b0;
        in_valid <= 1'b0;

        // Drain
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/i2p_pkg.sv
rtl/i2p_ctrl.sv
rtl/i2p_datapath.sv
rtl/infix_to_postfix_converter.sv
tb/postfix_check_pkg.sv
tb/tb_infix_to_postfix_converter.sv
